@@ rtl/core/csl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the c subset lexer
// token layout, class and scan mode codes, keyword spelling table
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int WORDS_HELD    = 9;
  localparam int MAX_TOKEN_LEN = 64;

  localparam logic [1:0] CLASS_KEYWORD  = 2'd0;
  localparam logic [1:0] CLASS_IDENT    = 2'd1;
  localparam logic [1:0] CLASS_OPERATOR = 2'd2;
  localparam logic [1:0] CLASS_NUMBER   = 2'd3;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // keyword spelling, first character in the lowest byte
  localparam logic [0:WORDS_HELD-1][63:0] WORD_TEXT = '{
    64'h00000000_00746e69,  // int
    64'h00000074_616f6c66,  // float
    64'h00000000_00006669,  // if
    64'h00000000_65736c65,  // else
    64'h00000065_6c696877,  // while
    64'h00006e72_75746572,  // return
    64'h00000000_00726f66,  // for
    64'h00000000_72616863,  // char
    64'h00000000_64696f76   // void
  };

  localparam logic [0:WORDS_HELD-1][2:0] WORD_LEN = '{
    3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd4
  };

  // first declared member sits in the highest bits
  typedef struct packed {
    logic        ovf;
    logic [31:0] start;
    logic [6:0]  len;
    logic [31:0] val;
    logic [7:0]  op;
    logic [3:0]  kw;
    logic [1:0]  cls;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } scan_res_t;

endpackage

@@ rtl/core/csl_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_scan: per-byte scanner state and token generation
// updates the pending token on each accepted item and forms up to two tokens
// ----------------------------------------------------------------------------
module csl_scan #(
  parameter int ACTIVE_WORDS = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          char_byte,
  input  logic                fin,
  output csl_pkg::scan_res_t  res
);
  import csl_pkg::*;

  logic [1:0]              mode_r, mode_nxt;
  logic [6:0]              len_r, len_nxt;
  logic [31:0]             start_r, start_nxt;
  logic [31:0]             pos_r, pos_nxt;
  logic [ACTIVE_WORDS-1:0] cand_r, cand_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;

  logic [1:0]              mode_a, mode_b;
  logic [6:0]              len_a, len_b;
  logic [31:0]             start_b;
  logic [ACTIVE_WORDS-1:0] cand_a, cand_b;
  logic [31:0]             acc_a, acc_b;
  logic                    ovf_a, ovf_b;
  logic                    is_letter, is_digit, is_oper;
  logic [35:0]             prod;
  logic                    fa_v, op_v, fb_v;
  token_t                  fa_tok, op_tok, fb_tok, sec_tok;
  logic                    sec_v;

  function automatic logic [ACTIVE_WORDS-1:0] narrow(
    input logic [ACTIVE_WORDS-1:0] c,
    input logic [6:0]              p,
    input logic [7:0]              b
  );
    logic [ACTIVE_WORDS-1:0] r;
    r = c;
    for (int k = 0; k < ACTIVE_WORDS; k++) begin
      if (p >= {4'd0, WORD_LEN[k]} || WORD_TEXT[k][{p[2:0], 3'b000} +: 8] != b) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic token_t flush(
    input logic [1:0]              m,
    input logic [ACTIVE_WORDS-1:0] c,
    input logic [6:0]              l,
    input logic [31:0]             s,
    input logic [31:0]             v,
    input logic                    o
  );
    token_t t;
    logic   found;
    t     = '0;
    found = 1'b0;
    t.len   = l;
    t.start = s;
    t.ovf   = o;
    if (m == MODE_NUMBER) begin
      t.cls = CLASS_NUMBER;
      t.val = v;
    end else begin
      t.cls = CLASS_IDENT;
      for (int k = 0; k < ACTIVE_WORDS; k++) begin
        if (!found && c[k] && l == {4'd0, WORD_LEN[k]}) begin
          found = 1'b1;
          t.cls = CLASS_KEYWORD;
          t.kw  = 4'(k);
        end
      end
    end
    return t;
  endfunction

  always_comb begin
    is_letter = char_byte inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f};
    is_digit  = char_byte inside {[8'h30:8'h39]};
    is_oper   = char_byte inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d,
                                  8'h3c, 8'h3e, 8'h21, 8'h26, 8'h7c};
    prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, char_byte[3:0]};

    // continue or end the pending token
    mode_a = mode_r;
    len_a  = len_r;
    cand_a = cand_r;
    acc_a  = acc_r;
    ovf_a  = ovf_r;
    fa_v   = 1'b0;
    fa_tok = flush(mode_r, cand_r, len_r, start_r, acc_r, ovf_r);
    case (mode_r)
      MODE_IDENT: begin
        if (is_letter || is_digit) begin
          cand_a = narrow(cand_r, len_r, char_byte);
          if (len_r < 7'(MAX_TOKEN_LEN)) len_a = len_r + 7'd1;
          else                           ovf_a = 1'b1;
        end else begin
          fa_v   = 1'b1;
          mode_a = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          if (prod[35:32] != 4'd0) begin
            acc_a = '1;
            ovf_a = 1'b1;
          end else begin
            acc_a = prod[31:0];
          end
          if (len_r < 7'(MAX_TOKEN_LEN)) len_a = len_r + 7'd1;
          else                           ovf_a = 1'b1;
        end else begin
          fa_v   = 1'b1;
          mode_a = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // handle the byte fresh from idle
    mode_b  = mode_a;
    len_b   = len_a;
    cand_b  = cand_a;
    acc_b   = acc_a;
    ovf_b   = ovf_a;
    start_b = start_r;
    op_v    = 1'b0;
    op_tok  = '0;
    op_tok.cls   = CLASS_OPERATOR;
    op_tok.op    = char_byte;
    op_tok.len   = 7'd1;
    op_tok.start = pos_r;
    if (mode_a == MODE_IDLE) begin
      if (is_letter) begin
        mode_b  = MODE_IDENT;
        start_b = pos_r;
        len_b   = 7'd1;
        ovf_b   = 1'b0;
        acc_b   = '0;
        cand_b  = narrow('1, 7'd0, char_byte);
      end else if (is_digit) begin
        mode_b  = MODE_NUMBER;
        start_b = pos_r;
        len_b   = 7'd1;
        ovf_b   = 1'b0;
        cand_b  = '0;
        acc_b   = {28'd0, char_byte[3:0]};
      end else if (is_oper) begin
        op_v = 1'b1;
      end
    end

    // end flag flushes what is left
    fb_v   = fin && mode_b != MODE_IDLE;
    fb_tok = flush(mode_b, cand_b, len_b, start_b, acc_b, ovf_b);

    sec_v   = op_v || fb_v;
    sec_tok = op_v ? op_tok : fb_tok;
    res.cnt  = 2'({1'b0, fa_v} + {1'b0, sec_v});
    res.tok0 = fa_v ? fa_tok : sec_tok;
    res.tok1 = sec_tok;

    mode_nxt  = fin ? MODE_IDLE : mode_b;
    len_nxt   = len_b;
    start_nxt = start_b;
    cand_nxt  = cand_b;
    acc_nxt   = acc_b;
    ovf_nxt   = ovf_b;
    pos_nxt   = pos_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      cand_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ rtl/core/c_subset_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer: byte-serial tokenizer for a small subset of c
// one ascii byte per input item, keyword / identifier / operator / number out
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one character per item in in_tdata, in_tlast marks the end
//   of input and flushes any pending token after that byte is handled.
//   out_ channel: one token per item; out_tlast marks the final token caused
//   by one input byte. an input byte causes zero, one or two tokens.
//   a token caused by a byte is written into the result queue when that byte
//   is accepted and is offered on out_ once it reaches the queue head.
//   throughput: one input byte per cycle while out_tready is high and each
//   byte causes at most one token; tokens leave one per item through the
//   single-token output port, which drains the four-entry result queue.
//   in_tready drops when fewer than two queue entries are free.
//   reset clears the scanner (idle, byte position zero) and empties the
//   queue. a stall on out_tready holds the head token and lets the queue
//   fill; input keeps flowing until the queue is nearly full.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
  parameter int KEYWORD_COUNT = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // token_class, keyword_index, operator_char,
                                  // number_value, token_length, start_position,
                                  // overflow, zero fill
  output logic        out_tlast   // last_of_run
);
  import csl_pkg::*;

  localparam int ActiveWords = (KEYWORD_COUNT < WORDS_HELD) ? KEYWORD_COUNT : WORDS_HELD;
  localparam int QDepth      = 4;

  typedef struct packed {
    token_t tok;
    logic   last;
  } q_ent_t;

  scan_res_t  res;
  logic       in_acc, out_acc;
  q_ent_t     q_r [QDepth];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  q_ent_t     head;

  csl_scan #(
    .ACTIVE_WORDS (ActiveWords)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .char_byte (in_tdata),
    .fin       (in_tlast),
    .res       (res)
  );

  assign in_tready  = count_r <= 3'(QDepth - 2);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = count_r != 3'd0;
  assign out_acc    = out_tvalid && out_tready;
  assign head       = q_r[rd_ptr_r];
  assign out_tdata  = {2'b00, head.tok};
  assign out_tlast  = head.last;

  always_comb begin
    wr_ptr_nxt = in_acc ? 2'(wr_ptr_r + res.cnt) : wr_ptr_r;
    rd_ptr_nxt = out_acc ? 2'(rd_ptr_r + 2'd1) : rd_ptr_r;
    count_nxt  = 3'(count_r + (in_acc ? {1'b0, res.cnt} : 3'd0) - {2'b00, out_acc});
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= '{tok: res.tok0, last: res.cnt == 2'd1};
    end
    if (in_acc && res.cnt == 2'd2) begin
      q_r[2'(wr_ptr_r + 2'd1)] <= '{tok: res.tok1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDepth))
    else $error("result queue count out of range");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 3'd0 |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with unequal pointers");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !in_acc) |=> count_r == 3'($past(count_r) - 3'd1))
    else $error("queue count not decremented on pop");
`endif

endmodule
